// ===== rtl/lfu_pkg.sv =====
// Shared widths, reset values and defaults for the LFU page-frame store.
// Used by the channel interfaces, the frame cell and the top level.
package lfu_pkg;

  // Field widths of the request and result words.
  localparam int PAGE_W       = 8;
  localparam int SLOT_W       = 2;
  localparam int SLOT_COUNT_W = 16;

  // Defaults for the top-level parameters.
  localparam int FRAMES_DEF     = 4;
  localparam int COUNT_BITS_DEF = 16;

  // Page number zero marks an empty frame.
  localparam logic [PAGE_W-1:0] EMPTY_PAGE     = 8'd0;
  localparam logic [PAGE_W-1:0] PAGE_LIMIT_RST = 8'd9;

endpackage

// ===== rtl/lfu_req_if.sv =====
// Request channel of the LFU page-frame store: one page number per word.
// Depends on lfu_pkg for the page width.
interface lfu_req_if import lfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

// ===== rtl/lfu_res_if.sv =====
// Result channel of the LFU page-frame store: one word per request.
// Depends on lfu_pkg for the field widths.
interface lfu_res_if import lfu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    rejected;
  logic                    hit;
  logic [SLOT_W-1:0]       slot;
  logic                    evicted;
  logic [PAGE_W-1:0]       evicted_page;
  logic [SLOT_COUNT_W-1:0] slot_count;

  modport source (output valid, output rejected, output hit, output slot, output evicted,
                  output evicted_page, output slot_count, input ready);
  modport sink   (input valid, input rejected, input hit, input slot, input evicted,
                  input evicted_page, input slot_count, output ready);
endinterface

// ===== rtl/lfu_page_replacement.sv =====
// Top level of the LFU page-frame store: request/result channels, the
// page_limit register, the row of frame cells and the write-back control.
// Depends on lfu_pkg, lfu_req_if, lfu_res_if and lfu_cell.
//
// Usage: each word on req carries a page number; each produces exactly one
// word on res, in order. A page of zero or above page_limit is rejected;
// when the output register is free its result is registered at the accept
// edge, so rejected words can stream one per cycle while it stays free. Any
// other page launches a scan record down a row of FRAMES cells, one cell per
// cycle; once the record leaves the last cell and the output register is
// free, the chosen frame is written back and the result word is registered.
// The next word is taken only after the record has passed the whole cell
// row, the frame has been written back and the sequencer is back in idle.
// A result waiting in the output register does not block accepting the next
// word; only when a second result is ready while the first is still stalled
// does the block hold it and drop req.ready until res.ready frees the slot.
// Reset empties every frame, clears the counts and sets page_limit to 9.
// page_limit is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while idle, and the block itself does not enforce this.
module lfu_page_replacement import lfu_pkg::*; #(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lfu_req_if.sink           req,
  lfu_res_if.source         res,
  input  logic              cfg_wr_en,
  input  logic [PAGE_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(FRAMES);

  typedef struct packed {
    logic [PAGE_W-1:0]     page;
    logic                  match_found;
    logic [IDX_W-1:0]      match_idx;
    logic [COUNT_BITS-1:0] match_count;
    logic                  empty_found;
    logic [IDX_W-1:0]      empty_idx;
    logic [IDX_W-1:0]      victim_idx;
    logic [COUNT_BITS-1:0] victim_count;
    logic [PAGE_W-1:0]     victim_page;
    logic                  spare;
  } scan_t;

  typedef struct packed {
    logic              vld;
    logic              fill;
    logic [IDX_W-1:0]  idx;
    logic [PAGE_W-1:0] page;
  } upd_t;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic              hold_rej;
  logic [PAGE_W-1:0] page_limit;

  scan_t             chain [FRAMES+1];
  logic [FRAMES:0]   chain_vld;
  scan_t             last;
  scan_t             rec_head;
  upd_t              upd;

  logic              acc;
  logic              rej_now;
  logic              out_free;
  logic              commit;
  logic              rej_emit;

  logic [IDX_W-1:0]      tgt;
  logic [COUNT_BITS-1:0] new_count;
  logic                  do_evict;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= PAGE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      page_limit <= cfg_wr_data;
    end
  end

  // Handshake terms.
  assign req.ready = (state == ST_IDLE);
  assign acc       = req.valid && req.ready;
  assign rej_now   = (req.page == EMPTY_PAGE) || (req.page > page_limit);
  assign out_free  = !res.valid || res.ready;

  // Decision on the finished scan record.
  assign last = chain[FRAMES];
  always_comb begin
    do_evict = 1'b0;
    if (last.match_found) begin
      tgt       = last.match_idx;
      new_count = (last.match_count == '1) ? last.match_count
                                           : last.match_count + 1'b1;
    end else if (last.empty_found) begin
      tgt       = last.empty_idx;
      new_count = COUNT_BITS'(1);
    end else begin
      tgt       = last.victim_idx;
      new_count = COUNT_BITS'(1);
      do_evict  = 1'b1;
    end
  end

  assign commit   = out_free && ((state == ST_SCAN && chain_vld[FRAMES]) ||
                                 (state == ST_HOLD && !hold_rej));
  assign rej_emit = out_free && ((acc && rej_now) || (state == ST_HOLD && hold_rej));

  assign upd.vld  = commit;
  assign upd.fill = !last.match_found;
  assign upd.idx  = tgt;
  assign upd.page = last.page;

  // Sequencer: scan, then write back or hold a reject until output is free.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (!rej_now) begin
            state_next = ST_SCAN;
          end else if (!out_free) begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_SCAN: begin
        if (chain_vld[FRAMES]) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      hold_rej <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        hold_rej <= rej_now;
      end
    end
  end

  // Head of the cell row: a fresh scan record for each valid page.
  always_comb begin
    rec_head      = '0;
    rec_head.page = req.page;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_vld[0] <= 1'b0;
    end else begin
      chain_vld[0] <= acc && !rej_now;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !rej_now) begin
      chain[0] <= rec_head;
    end
  end

  // Row of frame cells.
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lfu_cell #(
      .FRAMES     (FRAMES),
      .COUNT_BITS (COUNT_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .rec_in  (chain[i]),
      .vld_in  (chain_vld[i]),
      .rec_out (chain[i+1]),
      .vld_out (chain_vld[i+1]),
      .upd     (upd)
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (commit || rej_emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rej_emit) begin
      res.rejected     <= 1'b1;
      res.hit          <= 1'b0;
      res.slot         <= '0;
      res.evicted      <= 1'b0;
      res.evicted_page <= EMPTY_PAGE;
      res.slot_count   <= '0;
    end else if (commit) begin
      res.rejected     <= 1'b0;
      res.hit          <= last.match_found;
      res.slot         <= SLOT_W'(tgt);
      res.evicted      <= do_evict;
      res.evicted_page <= do_evict ? last.victim_page : EMPTY_PAGE;
      res.slot_count   <= SLOT_COUNT_W'(new_count);
    end
  end

  // Only one scan record is ever in flight.
  a_one_record: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_vld))
    else $error("more than one scan record in the cell row");

  // A record in the row means the sequencer is scanning.
  a_scan_state: assert property (@(posedge clk) disable iff (rst)
    (chain_vld != '0) |-> (state == ST_SCAN))
    else $error("scan record moving outside the scan state");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.hit && res.evicted))
    else $error("result word flags both hit and eviction");

  // Rejected words carry no frame information.
  a_rej_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.rejected) |-> (!res.hit && !res.evicted && res.slot_count == '0))
    else $error("rejected result word carries frame data");

  // Commit and reject never load the output register together.
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(commit && rej_emit))
    else $error("two result words loaded in one cycle");

endmodule

// ===== rtl/lfu_cell.sv =====
// One frame of the LFU store: holds a page and its use count, and folds its
// entry into the scan record that walks down the row. Depends on lfu_pkg.
module lfu_cell import lfu_pkg::*; #(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int INDEX      = 0,
  localparam int IDX_W     = $clog2(FRAMES)
) (
  input  logic clk,
  input  logic rst,
  input  logic [PAGE_W+3+3*IDX_W+2*COUNT_BITS+PAGE_W-1:0] rec_in,
  input  logic vld_in,
  output logic [PAGE_W+3+3*IDX_W+2*COUNT_BITS+PAGE_W-1:0] rec_out,
  output logic vld_out,
  input  logic [IDX_W+PAGE_W+1:0] upd
);

  typedef struct packed {
    logic [PAGE_W-1:0]     page;
    logic                  match_found;
    logic [IDX_W-1:0]      match_idx;
    logic [COUNT_BITS-1:0] match_count;
    logic                  empty_found;
    logic [IDX_W-1:0]      empty_idx;
    logic [IDX_W-1:0]      victim_idx;
    logic [COUNT_BITS-1:0] victim_count;
    logic [PAGE_W-1:0]     victim_page;
    logic                  spare;
  } scan_t;

  typedef struct packed {
    logic              vld;
    logic              fill;
    logic [IDX_W-1:0]  idx;
    logic [PAGE_W-1:0] page;
  } upd_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [PAGE_W-1:0]     page;
  logic [COUNT_BITS-1:0] count;
  scan_t                 rin;
  scan_t                 rnext;
  upd_t                  u;

  assign rin = scan_t'(rec_in);
  assign u   = upd_t'(upd);

  // Fold this frame into the record: first match, first empty, smallest count.
  always_comb begin
    rnext = rin;
    if (!rin.match_found && page == rin.page) begin
      rnext.match_found = 1'b1;
      rnext.match_idx   = MY_IDX;
      rnext.match_count = count;
    end
    if (!rin.empty_found && page == EMPTY_PAGE) begin
      rnext.empty_found = 1'b1;
      rnext.empty_idx   = MY_IDX;
    end
    if (INDEX == 0 || count < rin.victim_count) begin
      rnext.victim_idx   = MY_IDX;
      rnext.victim_count = count;
      rnext.victim_page  = page;
    end
  end

  // The record moves one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      rec_out <= rnext;
    end
  end

  // Write-back from the controller: place a new page or count a hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      page  <= EMPTY_PAGE;
      count <= '0;
    end else if (u.vld && u.idx == MY_IDX) begin
      if (u.fill) begin
        page  <= u.page;
        count <= COUNT_BITS'(1);
      end else if (count != '1) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule
